[hdl/isa_dma_channel_setup_unit_assert.svh]
// Assertion macros for the ISA DMA channel setup unit.
// Depends on nothing; taken in by the checker module.
`ifndef ISA_DMA_CHANNEL_SETUP_UNIT_ASSERT_SVH
`define ISA_DMA_CHANNEL_SETUP_UNIT_ASSERT_SVH

// Implication in the same cycle, disabled during reset.
`define ISADMA_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Implication into the next cycle, disabled during reset.
`define ISADMA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hdl/isadma_pkg.sv]
// Shared types, constants and port tables of the ISA DMA channel setup unit.
// Depends on nothing.
package isadma_pkg;

    localparam logic [24:0] ADDR_LIMIT   = 25'h100_0000;
    localparam logic [31:0] MAX_COUNT    = 32'h0001_0000;
    localparam logic [7:0]  MASK_SET_BIT = 8'h04;
    localparam logic [2:0]  LOCAL_MASK   = 3'h3;
    localparam logic [2:0]  CH_INVALID   = 3'd4;
    localparam logic [2:0]  CH_WIDE_MIN  = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [7:0]  mode_byte;
        logic [2:0]  channel;
        logic [31:0] phys_address;
        logic [31:0] byte_size;
    } req_t;

    typedef struct packed {
        logic [7:0] port;
        logic [7:0] write_data;
        logic       rejected;
        logic       last;
    } res_t;

    typedef struct packed {
        logic        rejected;
        logic [2:0]  channel;
        logic [7:0]  mode_byte;
        logic [7:0]  page;
        logic [15:0] offset;
        logic [15:0] count_m1;
    } desc_t;

    typedef enum logic [3:0] {
        STEP_MASK_SET,
        STEP_FF_CLEAR,
        STEP_MODE,
        STEP_PAGE,
        STEP_ADDR_LO,
        STEP_ADDR_HI,
        STEP_CNT_LO,
        STEP_CNT_HI,
        STEP_MASK_CLEAR
    } step_t;

    function automatic logic [7:0] mask_port(input logic [2:0] ch);
        mask_port = ch[2] ? 8'hD4 : 8'h0A;
    endfunction

    function automatic logic [7:0] mode_port(input logic [2:0] ch);
        mode_port = ch[2] ? 8'hD6 : 8'h0B;
    endfunction

    function automatic logic [7:0] clear_port(input logic [2:0] ch);
        clear_port = ch[2] ? 8'hD8 : 8'h0C;
    endfunction

    function automatic logic [7:0] page_port(input logic [2:0] ch);
        logic [7:0] p;
        case (ch)
            3'd0:    p = 8'h87;
            3'd1:    p = 8'h83;
            3'd2:    p = 8'h81;
            3'd3:    p = 8'h82;
            3'd4:    p = 8'h8F;
            3'd5:    p = 8'h8B;
            3'd6:    p = 8'h89;
            3'd7:    p = 8'h8A;
            default: p = 8'h00;
        endcase
        page_port = p;
    endfunction

    function automatic logic [7:0] addr_port(input logic [2:0] ch);
        addr_port = ch[2] ? (8'hC0 + {4'd0, ch[1:0], 2'b00})
                          : {5'd0, ch[1:0], 1'b0};
    endfunction

    function automatic logic [7:0] cnt_port(input logic [2:0] ch);
        cnt_port = addr_port(ch) + (ch[2] ? 8'h02 : 8'h01);
    endfunction

endpackage

[hdl/isadma_front.sv]
// Front end: checks one request and turns it into a channel descriptor.
// Depends on isadma_pkg.
module isadma_front
(
    input  isadma_pkg::req_t  request,
    output isadma_pkg::desc_t desc
);

    logic [24:0] limit;
    logic        addr_bad;
    logic        size_over;
    logic        wide;
    logic        odd;
    logic [31:0] dma_cnt;
    logic        cnt_bad;
    logic        bad;

    always_comb
    begin
        addr_bad  = |request.phys_address[31:24];
        limit     = isadma_pkg::ADDR_LIMIT - {1'b0, request.phys_address[23:0]};
        size_over = request.byte_size > {7'd0, limit};
        wide      = request.channel >= isadma_pkg::CH_WIDE_MIN;
        odd       = request.phys_address[0] | request.byte_size[0];
        dma_cnt   = wide ? {1'b0, request.byte_size[31:1]} : request.byte_size;
        cnt_bad   = (dma_cnt == 32'd0) || (dma_cnt > isadma_pkg::MAX_COUNT);
        bad       = (request.channel == isadma_pkg::CH_INVALID)
                 || (request.byte_size == 32'd0)
                 || addr_bad || size_over || (wide && odd) || cnt_bad;

        desc.rejected  = bad;
        desc.channel   = request.channel;
        desc.mode_byte = request.mode_byte;
        desc.page      = request.phys_address[23:16];
        desc.offset    = wide ? request.phys_address[16:1] : request.phys_address[15:0];
        desc.count_m1  = dma_cnt[15:0] - 16'd1;
    end

endmodule

[hdl/isadma_queue.sv]
// Short descriptor queue between the front end and the write sequencer.
// Depends on isadma_pkg.
module isadma_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  isadma_pkg::desc_t push_data,
    input  logic              pop,
    output isadma_pkg::desc_t head,
    output logic              empty,
    output logic              full
);

    isadma_pkg::desc_t entry_reg [isadma_pkg::QUEUE_DEPTH];

    logic [isadma_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [isadma_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [isadma_pkg::QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        empty       = count_reg == '0;
        full        = count_reg == isadma_pkg::QCNT_W'(isadma_pkg::QUEUE_DEPTH);
        head        = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/isadma_back.sv]
// Write sequencer: plays out the port writes of one descriptor, one a cycle.
// Depends on isadma_pkg.
module isadma_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  isadma_pkg::desc_t head,
    input  logic              empty,
    output logic              pop,
    output logic              result_strobe,
    output isadma_pkg::res_t  result
);

    isadma_pkg::step_t step_reg, step_next;
    logic              strobe_reg, strobe_next;
    isadma_pkg::res_t  result_reg, result_next;
    logic [7:0]        local_ch;

    always_comb
    begin
        local_ch    = {5'd0, head.channel & isadma_pkg::LOCAL_MASK};
        step_next   = step_reg;
        strobe_next = 1'b0;
        pop         = 1'b0;
        result_next = '0;
        if (!empty)
        begin
            strobe_next = 1'b1;
            if (head.rejected)
            begin
                result_next.rejected = 1'b1;
                result_next.last     = 1'b1;
                pop                  = 1'b1;
                step_next            = isadma_pkg::STEP_MASK_SET;
            end
            else
            begin
                case (step_reg)
                    isadma_pkg::STEP_MASK_SET:
                    begin
                        result_next.port       = isadma_pkg::mask_port(head.channel);
                        result_next.write_data = isadma_pkg::MASK_SET_BIT | local_ch;
                        step_next              = isadma_pkg::STEP_FF_CLEAR;
                    end
                    isadma_pkg::STEP_FF_CLEAR:
                    begin
                        result_next.port = isadma_pkg::clear_port(head.channel);
                        step_next        = isadma_pkg::STEP_MODE;
                    end
                    isadma_pkg::STEP_MODE:
                    begin
                        result_next.port       = isadma_pkg::mode_port(head.channel);
                        result_next.write_data = head.mode_byte | local_ch;
                        step_next              = isadma_pkg::STEP_PAGE;
                    end
                    isadma_pkg::STEP_PAGE:
                    begin
                        result_next.port       = isadma_pkg::page_port(head.channel);
                        result_next.write_data = head.page;
                        step_next              = isadma_pkg::STEP_ADDR_LO;
                    end
                    isadma_pkg::STEP_ADDR_LO:
                    begin
                        result_next.port       = isadma_pkg::addr_port(head.channel);
                        result_next.write_data = head.offset[7:0];
                        step_next              = isadma_pkg::STEP_ADDR_HI;
                    end
                    isadma_pkg::STEP_ADDR_HI:
                    begin
                        result_next.port       = isadma_pkg::addr_port(head.channel);
                        result_next.write_data = head.offset[15:8];
                        step_next              = isadma_pkg::STEP_CNT_LO;
                    end
                    isadma_pkg::STEP_CNT_LO:
                    begin
                        result_next.port       = isadma_pkg::cnt_port(head.channel);
                        result_next.write_data = head.count_m1[7:0];
                        step_next              = isadma_pkg::STEP_CNT_HI;
                    end
                    isadma_pkg::STEP_CNT_HI:
                    begin
                        result_next.port       = isadma_pkg::cnt_port(head.channel);
                        result_next.write_data = head.count_m1[15:8];
                        step_next              = isadma_pkg::STEP_MASK_CLEAR;
                    end
                    isadma_pkg::STEP_MASK_CLEAR:
                    begin
                        result_next.port       = isadma_pkg::mask_port(head.channel);
                        result_next.write_data = local_ch;
                        result_next.last       = 1'b1;
                        pop                    = 1'b1;
                        step_next              = isadma_pkg::STEP_MASK_SET;
                    end
                    default:
                    begin
                        strobe_next = 1'b0;
                        step_next   = isadma_pkg::STEP_MASK_SET;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= isadma_pkg::STEP_MASK_SET;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

[hdl/isa_dma_channel_setup_unit.sv]
// ISA DMA channel setup unit: checks a request and emits the 8237 port writes.
// Start is registered in the queue, each write in the result register; rejects give one item.
// Requests are paced by the write sequencer, which plays one port write a cycle.
// A two-entry descriptor queue takes new requests while the sequencer runs; busy = queue full.
// Reset (rst_n low, asynchronous) empties the queue and returns the sequencer to its first step.
// Depends on isadma_pkg, isadma_front, isadma_queue, isadma_back.
module isa_dma_channel_setup_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  isadma_pkg::req_t  request,
    output logic              result_strobe,
    output isadma_pkg::res_t  result
);

    isadma_pkg::desc_t front_desc;
    isadma_pkg::desc_t head;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;

    assign busy = full;
    assign push = start && !full;

    isadma_front u_front
    (
        .request (request),
        .desc    (front_desc)
    );

    isadma_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_desc),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    isadma_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

[hdl/isadma_checker.sv]
// Port-level checks of the ISA DMA channel setup unit, bound to the top level.
// Depends on isadma_pkg and isa_dma_channel_setup_unit_assert.svh.
`include "isa_dma_channel_setup_unit_assert.svh"

module isadma_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             result_strobe,
    input isadma_pkg::res_t result
);

    `ISADMA_ASSERT_SAME(a_reject_single, clk, rst_n, result_strobe && result.rejected, result.last && result.port == 8'h00 && result.write_data == 8'h00, "rejected item not a lone zero item")
    `ISADMA_ASSERT_NEXT(a_seq_unbroken, clk, rst_n, result_strobe && !result.last, result_strobe, "write sequence broken")
    `ISADMA_ASSERT_NEXT(a_seq_no_reject, clk, rst_n, result_strobe && !result.last, !result.rejected, "reject inside write sequence")
    `ISADMA_ASSERT_SAME(a_mask_clear, clk, rst_n, result_strobe && result.last && !result.rejected, result.write_data[2] == 1'b0, "final write sets mask")

endmodule

bind isa_dma_channel_setup_unit isadma_checker u_isadma_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .result_strobe (result_strobe),
    .result        (result)
);
